// ===== hw/rtl/mm3_pkg.sv =====
package mm3_pkg;

    localparam logic [63:0] MIX_C1  = 64'h87C3_7B91_1142_53D5;
    localparam logic [63:0] MIX_C2  = 64'h4CF5_AD43_2745_937F;
    localparam logic [63:0] FIN_C1  = 64'hFF51_AFD7_ED55_8CCD;
    localparam logic [63:0] FIN_C2  = 64'hC4CE_B9FE_1A85_EC53;
    localparam logic [63:0] ADD_ONE = 64'h0000_0000_52DC_E729;
    localparam logic [63:0] ADD_TWO = 64'h0000_0000_3849_5AB5;

    typedef struct packed {
        logic        start;
        logic [63:0] a;
        logic [63:0] b;
    } t_mul_req;

    typedef struct packed {
        logic        done;
        logic [63:0] prod;
    } t_mul_rsp;

    // keep the lowest n bytes, n of eight or more keeps all
    function automatic logic [63:0] byte_mask(input logic [3:0] n);
        logic [63:0] m;
        m = '0;
        for (int i = 0; i < 8; i++) begin
            if (n > 4'(i)) begin
                m[i*8 +: 8] = 8'hFF;
            end
        end
        return m;
    endfunction

endpackage

// ===== hw/rtl/mm3_mul.sv =====
module mm3_mul (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  mm3_pkg::t_mul_req i_req,
    output mm3_pkg::t_mul_rsp o_rsp
);
    import mm3_pkg::*;

    logic        r_busy;
    logic [1:0]  r_cnt;
    logic        r_done;
    logic [63:0] r_a;
    logic [63:0] r_b;
    logic [63:0] r_prod;
    logic [63:0] r_acc;
    logic [31:0] r_hi;
    logic [31:0] n_ma;
    logic [31:0] n_mb;

    // low 64 bits of a 64x64 product from three 32x32 partial products
    always_comb begin
        n_ma = r_a[31:0];
        n_mb = r_b[31:0];
        if (r_cnt == 2'd1) begin
            n_ma = r_a[63:32];
        end else if (r_cnt != 2'd0) begin
            n_mb = r_b[63:32];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= 2'd0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (!r_busy) begin
                if (i_req.start) begin
                    r_busy <= 1'b1;
                    r_cnt  <= 2'd0;
                end
            end else begin
                r_cnt <= r_cnt + 2'd1;
                if (r_cnt == 2'd3) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_busy && i_req.start) begin
            r_a <= i_req.a;
            r_b <= i_req.b;
        end
        if (r_busy) begin
            r_prod <= 64'(n_ma) * 64'(n_mb);
        end
        if (r_busy && r_cnt == 2'd1) begin
            r_acc <= r_prod;
        end
        if (r_busy && r_cnt == 2'd2) begin
            r_hi <= r_prod[31:0];
        end
        if (r_busy && r_cnt == 2'd3) begin
            r_acc[63:32] <= r_acc[63:32] + r_hi + r_prod[31:0];
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.prod = r_acc;

endmodule

// ===== hw/rtl/mm3_core.sv =====
module mm3_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [63:0] i_lo,
    input  logic [63:0] i_hi,
    input  logic [4:0]  i_cnt,
    input  logic        i_last,
    input  logic [63:0] i_seed,
    input  logic        i_out_free,
    output logic        o_busy,
    output logic        o_done,
    output logic [63:0] o_hash
);
    import mm3_pkg::*;

    localparam logic [4:0] S_IDLE = 5'd0;
    localparam logic [4:0] S_K1A  = 5'd1;
    localparam logic [4:0] S_K1B  = 5'd2;
    localparam logic [4:0] S_H1A  = 5'd3;
    localparam logic [4:0] S_H1B  = 5'd4;
    localparam logic [4:0] S_T1   = 5'd5;
    localparam logic [4:0] S_K2A  = 5'd6;
    localparam logic [4:0] S_K2B  = 5'd7;
    localparam logic [4:0] S_H2A  = 5'd8;
    localparam logic [4:0] S_H2B  = 5'd9;
    localparam logic [4:0] S_T2   = 5'd10;
    localparam logic [4:0] S_F0   = 5'd11;
    localparam logic [4:0] S_F1   = 5'd12;
    localparam logic [4:0] S_F2   = 5'd13;
    localparam logic [4:0] S_M1   = 5'd14;
    localparam logic [4:0] S_M2   = 5'd15;
    localparam logic [4:0] S_M3   = 5'd16;
    localparam logic [4:0] S_M4   = 5'd17;
    localparam logic [4:0] S_EMIT = 5'd18;

    logic [4:0]  r_state;
    logic        r_issued;
    logic        r_in_msg;
    logic        r_full;
    logic        r_do_k2;
    logic        r_last;
    logic [63:0] r_h1;
    logic [63:0] r_h2;
    logic [63:0] r_k1;
    logic [63:0] r_k2;
    logic [63:0] r_len;

    logic [4:0]  n_cnt_sat;
    logic        n_full;
    logic        n_do_k1;
    logic        n_do_k2;
    logic [63:0] n_fm1;
    logic [63:0] n_fm2;
    logic        n_is_mul;
    t_mul_req    n_req;
    t_mul_rsp    n_rsp;

    mm3_mul u_mul (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (n_req),
        .o_rsp  (n_rsp)
    );

    assign n_cnt_sat = (i_cnt > 5'd16) ? 5'd16 : i_cnt;
    assign n_full    = !i_last || (n_cnt_sat == 5'd16);
    assign n_do_k1   = n_full || (n_cnt_sat != 5'd0);
    assign n_do_k2   = n_full || (n_cnt_sat > 5'd8);

    assign n_fm1 = r_h1 ^ (r_h1 >> 33);
    assign n_fm2 = r_h2 ^ (r_h2 >> 33);

    assign n_is_mul = (r_state == S_K1A) || (r_state == S_K1B) || (r_state == S_K2A)
                   || (r_state == S_K2B) || (r_state == S_M1) || (r_state == S_M2)
                   || (r_state == S_M3) || (r_state == S_M4);

    always_comb begin
        n_req.start = n_is_mul && !r_issued;
        n_req.a     = r_k1;
        n_req.b     = MIX_C1;
        unique case (r_state)
            S_K1B: begin
                n_req.a = {r_k1[32:0], r_k1[63:33]};
                n_req.b = MIX_C2;
            end
            S_K2A: begin
                n_req.a = r_k2;
                n_req.b = MIX_C2;
            end
            S_K2B: begin
                n_req.a = {r_k2[30:0], r_k2[63:31]};
                n_req.b = MIX_C1;
            end
            S_M1: begin
                n_req.a = n_fm1;
                n_req.b = FIN_C1;
            end
            S_M2: begin
                n_req.a = n_fm1;
                n_req.b = FIN_C2;
            end
            S_M3: begin
                n_req.a = n_fm2;
                n_req.b = FIN_C1;
            end
            S_M4: begin
                n_req.a = n_fm2;
                n_req.b = FIN_C2;
            end
            default: begin
                n_req.a = r_k1;
                n_req.b = MIX_C1;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_issued <= 1'b0;
            r_in_msg <= 1'b0;
        end else begin
            if (n_req.start) begin
                r_issued <= 1'b1;
            end
            if (n_rsp.done) begin
                r_issued <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        r_in_msg <= 1'b1;
                        if (n_do_k1) begin
                            r_state <= S_K1A;
                        end else begin
                            r_state <= S_F0;
                        end
                    end
                end
                S_K1A: if (n_rsp.done) r_state <= S_K1B;
                S_K1B: begin
                    if (n_rsp.done) begin
                        r_state <= r_full ? S_H1A : S_T1;
                    end
                end
                S_H1A: r_state <= S_H1B;
                S_H1B, S_T1: r_state <= r_do_k2 ? S_K2A : S_F0;
                S_K2A: if (n_rsp.done) r_state <= S_K2B;
                S_K2B: begin
                    if (n_rsp.done) begin
                        r_state <= r_full ? S_H2A : S_T2;
                    end
                end
                S_H2A: r_state <= S_H2B;
                S_H2B: r_state <= r_last ? S_F0 : S_IDLE;
                S_T2:  r_state <= S_F0;
                S_F0:  r_state <= S_F1;
                S_F1:  r_state <= S_F2;
                S_F2:  r_state <= S_M1;
                S_M1:  if (n_rsp.done) r_state <= S_M2;
                S_M2:  if (n_rsp.done) r_state <= S_M3;
                S_M3:  if (n_rsp.done) r_state <= S_M4;
                S_M4:  if (n_rsp.done) r_state <= S_EMIT;
                S_EMIT: begin
                    if (i_out_free) begin
                        r_state  <= S_IDLE;
                        r_in_msg <= 1'b0;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    r_full  <= n_full;
                    r_do_k2 <= n_do_k2;
                    r_last  <= i_last;
                    r_k1    <= n_full ? i_lo : (i_lo & byte_mask(n_cnt_sat[3:0]));
                    r_k2    <= n_full ? i_hi : (i_hi & byte_mask(n_cnt_sat[3:0] - 4'd8));
                    r_len   <= (r_in_msg ? r_len : 64'd0)
                             + {59'd0, (i_last ? n_cnt_sat : 5'd16)};
                    if (!r_in_msg) begin
                        r_h1 <= i_seed;
                        r_h2 <= i_seed;
                    end
                end
            end
            S_K1A, S_K1B: if (n_rsp.done) r_k1 <= n_rsp.prod;
            S_K2A, S_K2B: if (n_rsp.done) r_k2 <= n_rsp.prod;
            S_M1, S_M2:   if (n_rsp.done) r_h1 <= n_rsp.prod;
            S_M3, S_M4:   if (n_rsp.done) r_h2 <= n_rsp.prod;
            S_H1A: r_h1 <= {r_h1[36:0] ^ r_k1[36:0], r_h1[63:37] ^ r_k1[63:37]} + r_h2;
            S_H1B: r_h1 <= {r_h1[61:0], 2'b00} + r_h1 + ADD_ONE;
            S_T1:  r_h1 <= r_h1 ^ r_k1;
            S_H2A: r_h2 <= {r_h2[32:0] ^ r_k2[32:0], r_h2[63:33] ^ r_k2[63:33]} + r_h1;
            S_H2B: r_h2 <= {r_h2[61:0], 2'b00} + r_h2 + ADD_TWO;
            S_T2:  r_h2 <= r_h2 ^ r_k2;
            S_F0: begin
                r_h1 <= r_h1 ^ r_len;
                r_h2 <= r_h2 ^ r_len;
            end
            S_F1: r_h1 <= r_h1 + r_h2;
            S_F2: r_h2 <= r_h2 + r_h1;
            default: begin
            end
        endcase
    end

    assign o_busy = (r_state != S_IDLE);
    assign o_done = (r_state == S_EMIT) && i_out_free;
    assign o_hash = n_fm1 + n_fm2;

endmodule

// ===== hw/rtl/murmur3_128_hash_first_word.sv =====
// murmurhash3 x64_128 over a stream of 16-byte blocks, first digest word out
//
// input stream: tdata holds data_low, data_high and byte_count, tlast ends
// a message; byte_count only matters on the last request and saturates at 16
// output stream: one 64-bit hash per message, after its last request
// config: i_cfg_we writes the seed, used when the next message starts
//
// one request is taken at a time; tready stays low while it is worked on.
// all 64-bit multiplies share one 32x32 multiplier, three partial products
// each. a full block takes two body multiplies per lane; a last request
// also takes four fmix multiplies before its result shows.
//
// reset clears the seed to zero and empties the output register. a finished
// hash sits in the output register while the receiver stalls; the next
// message is accepted meanwhile and its result waits until that register
// drains.
module murmur3_128_hash_first_word (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_axis_tvalid,
    output logic         o_s_axis_tready,
    // data_low [63:0], data_high [127:64], byte_count [132:128], zero pad
    input  logic [135:0] i_s_axis_tdata,
    input  logic         i_s_axis_tlast,
    output logic         o_m_axis_tvalid,
    input  logic         i_m_axis_tready,
    // hash [63:0]
    output logic [63:0]  o_m_axis_tdata,
    input  logic         i_cfg_we,
    input  logic [63:0]  i_cfg_wdata
);
    import mm3_pkg::*;

    logic [63:0] r_seed;
    logic        r_out_valid;
    logic [63:0] r_hash;
    logic        n_busy;
    logic        n_done;
    logic [63:0] n_hash;
    logic        n_out_free;
    logic        n_accept;

    assign n_out_free      = !r_out_valid || i_m_axis_tready;
    assign o_s_axis_tready = !n_busy;
    assign n_accept        = i_s_axis_tvalid && o_s_axis_tready;

    mm3_core u_core (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (n_accept),
        .i_lo      (i_s_axis_tdata[63:0]),
        .i_hi      (i_s_axis_tdata[127:64]),
        .i_cnt     (i_s_axis_tdata[132:128]),
        .i_last    (i_s_axis_tlast),
        .i_seed    (r_seed),
        .i_out_free(n_out_free),
        .o_busy    (n_busy),
        .o_done    (n_done),
        .o_hash    (n_hash)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seed      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_seed <= i_cfg_wdata;
            end
            if (n_done) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (n_done) begin
            r_hash <= n_hash;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_hash;

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        n_accept |=> !o_s_axis_tready)
        else $error("input accepted again while a request is in work");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        n_done |-> (!r_out_valid || i_m_axis_tready))
        else $error("result would overwrite an undelivered hash");

    a_done_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        n_done |=> o_m_axis_tvalid)
        else $error("finished hash not presented");

endmodule
